// ===== design/urdm_pkg.sv =====
// ----------------------------------------------------------------------------
// urdm_pkg
// Shared types and constants for the distinct-row mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package urdm_pkg;

    localparam int ELEM_W = 32;
    localparam int CFG_W  = 4;
    localparam int IDX_W  = 8;

    typedef struct packed {
        logic signed [ELEM_W-1:0] element;
        logic                     restart;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0] unique_index;
        logic             is_new;
        logic             overflow;
    } t_out_item;

endpackage

`default_nettype wire

// ===== design/urdm_ram.sv =====
// ----------------------------------------------------------------------------
// urdm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module urdm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                          i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== design/unique_row_dedup_mapper_top.sv =====
// ----------------------------------------------------------------------------
// unique_row_dedup_mapper_top
// Maps each row of an integer matrix to the index of its first distinct copy.
// ----------------------------------------------------------------------------
// Elements arrive row-major on the input channel (valid/stall). A transfer with
// restart set empties the distinct-row table before its element is taken.
// i_cfg_we writes the row length; the user must write it only while the block
// is idle, which the block does not enforce. A non-final element of a row is
// taken and gives no result. The final element starts the sequencer, which
// walks the stored rows through one word comparator: for each row it reads a
// table word and the matching buffer word (S_RD) and compares them (S_CMP),
// moving to the next row at the first mismatch and stopping at the first
// equal row. A new row is then written word by word, reading each buffer word
// (S_SRD) and writing it (S_SWR), words past the row length as zero.
// The result is held in an output register until its transfer completes; the
// input is stalled from the final element until then. When the table is full
// a new row gives overflow and is not stored. Reset empties the table, clears
// the column position and sets the row length to one.
// ----------------------------------------------------------------------------
`default_nettype none

module unique_row_dedup_mapper_top #(
    parameter int MAX_COLS = 8,
    parameter int MAX_ROWS = 256
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire urdm_pkg::t_in_item         i_in_data,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output urdm_pkg::t_out_item             o_out_data,
    input  wire logic                       i_cfg_we,
    input  wire logic [urdm_pkg::CFG_W-1:0] i_cfg_data
);

    import urdm_pkg::*;

    localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = $clog2(MAX_ROWS + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_RD    = 3'd2;
    localparam logic [2:0] S_CMP   = 3'd3;
    localparam logic [2:0] S_SRD   = 3'd4;
    localparam logic [2:0] S_SWR   = 3'd5;
    localparam logic [2:0] S_RESP  = 3'd6;

    logic [2:0]       r_state, n_state;
    logic [CFG_W-1:0] r_row_len;
    logic [CW-1:0]    r_col, n_col;
    logic [SW-1:0]    r_count, n_count;
    logic [SW-1:0]    r_slot, n_slot;
    logic [AW-1:0]    r_base, n_base;
    logic [CW-1:0]    r_k, n_k;
    t_out_item        r_out, n_out;

    logic [7:0]        len8;
    logic [7:0]        col_eff8;
    logic [CW-1:0]     col_eff;
    logic              accept;
    logic [AW-1:0]     tbl_addr;
    logic              tbl_we;
    logic [ELEM_W-1:0] tbl_wdata;
    logic [ELEM_W-1:0] tbl_q;
    logic [ELEM_W-1:0] buf_q;
    logic              k_last;
    logic              k_in_row;

    always_comb begin
        if (r_row_len == '0) begin
            len8 = 8'd1;
        end else if ({4'b0, r_row_len} > 8'(MAX_COLS)) begin
            len8 = 8'(MAX_COLS);
        end else begin
            len8 = {4'b0, r_row_len};
        end
    end

    assign accept   = i_in_valid && !o_in_stall;
    assign col_eff  = (i_in_data.restart || (8'(r_col) >= len8)) ? '0 : r_col;
    assign col_eff8 = 8'(col_eff);
    assign tbl_addr = r_base + AW'(r_k);
    assign k_last   = (8'(r_k) + 8'd1) == len8;
    assign k_in_row = 8'(r_k) < len8;
    assign tbl_we   = (r_state == S_SWR);
    assign tbl_wdata = k_in_row ? buf_q : '0;

    urdm_ram #(
        .WIDTH(ELEM_W),
        .DEPTH(MAX_COLS)
    ) u_row_buf (
        .i_clk  (i_clk),
        .i_we   (accept),
        .i_waddr(col_eff),
        .i_wdata(i_in_data.element),
        .i_raddr(r_k),
        .o_rdata(buf_q)
    );

    urdm_ram #(
        .WIDTH(ELEM_W),
        .DEPTH(DEPTH)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (tbl_we),
        .i_waddr(tbl_addr),
        .i_wdata(tbl_wdata),
        .i_raddr(tbl_addr),
        .o_rdata(tbl_q)
    );

    always_comb begin
        n_state = r_state;
        n_col   = r_col;
        n_count = r_count;
        n_slot  = r_slot;
        n_base  = r_base;
        n_k     = r_k;
        n_out   = r_out;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_in_data.restart) begin
                        n_count = '0;
                    end
                    if ((col_eff8 + 8'd1) < len8) begin
                        n_col = CW'(col_eff8 + 8'd1);
                    end else begin
                        n_col   = '0;
                        n_slot  = '0;
                        n_base  = '0;
                        n_k     = '0;
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                n_k = '0;
                if (r_slot < r_count) begin
                    n_state = S_RD;
                end else if (r_count == SW'(MAX_ROWS)) begin
                    n_out.unique_index = '0;
                    n_out.is_new       = 1'b0;
                    n_out.overflow     = 1'b1;
                    n_state            = S_RESP;
                end else begin
                    n_state = S_SRD;
                end
            end
            S_RD: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (tbl_q == buf_q) begin
                    if (k_last) begin
                        n_out.unique_index = IDX_W'(r_slot);
                        n_out.is_new       = 1'b0;
                        n_out.overflow     = 1'b0;
                        n_state            = S_RESP;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = S_RD;
                    end
                end else begin
                    n_slot  = r_slot + 1'b1;
                    n_base  = r_base + AW'(MAX_COLS);
                    n_state = S_CHECK;
                end
            end
            S_SRD: begin
                n_state = S_SWR;
            end
            S_SWR: begin
                if (8'(r_k) == 8'(MAX_COLS - 1)) begin
                    n_count            = r_count + 1'b1;
                    n_out.unique_index = IDX_W'(r_slot);
                    n_out.is_new       = 1'b1;
                    n_out.overflow     = 1'b0;
                    n_state            = S_RESP;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = S_SRD;
                end
            end
            S_RESP: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_row_len <= CFG_W'(1);
            r_col     <= '0;
            r_count   <= '0;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
            r_count <= n_count;
            if (i_cfg_we) begin
                r_row_len <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
        r_base <= n_base;
        r_k    <= n_k;
        r_out  <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_RESP);
    assign o_out_data  = r_out;

endmodule

`default_nettype wire
